>>> design/art_pkg.sv
// Shared types and constants for the allocation range tracker.
`default_nettype none

package art_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 32;
    localparam int END_W  = ADDR_W + 1;

    // Input opcodes
    typedef enum logic [1:0] {
        OP_ALLOC      = 2'd0,
        OP_FREE       = 2'd1,
        OP_FREE_EXACT = 2'd2,
        OP_FREE_ANY   = 2'd3
    } t_op;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERLAP   = 3'd1;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd2;
    localparam logic [2:0] ST_INSIDE    = 3'd3;
    localparam logic [2:0] ST_MISMATCH  = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_WR_A,
        S_WR_B,
        S_RESP
    } t_state;

    // Table update chosen after the scan
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ALLOC,
        ACT_REMOVE,
        ACT_TRIM,
        ACT_SPLIT,
        ACT_SPLIT_TAIL
    } t_act;

    // Compare unit result for one table entry
    typedef struct packed {
        logic              overlap;
        logic              contain;
        logic [END_W-1:0]  ent_end;
    } t_cmp_res;

endpackage

`default_nettype wire

>>> design/allocation_range_tracker_core.sv
// Top level of the allocation range tracker: sequencer, valid bits and entry table.
//
// Use: one request word enters on the s_axis channel (opcode, address, length) and
// exactly one response word leaves on the m_axis channel (status, trimmed).
// The block handles one word at a time: s_axis_tready is high only while idle.
// Each request is checked against every table entry by a single compare unit,
// one entry per cycle, fed from the entry RAM (one read port, registered data).
// After accept, the sequencer scans all entries (S_SCAN), takes the last read
// data (S_DRAIN), decides (S_DECIDE), then updates the table in S_WR_A and,
// only for a split that keeps a tail, in S_WR_B as well, before S_RESP; S_WR_A
// is skipped when the table does not change. A new word is taken only once the
// previous response has been accepted and the sequencer is back in idle.
// The response is held in a register until m_axis_tready is seen; while the
// receiver stalls, no new request is taken.
// Reset (synchronous, active low) clears all valid bits, so the table is empty;
// entry base and length storage is not cleared and needs no clearing pass.
`default_nettype none

module allocation_range_tracker_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tdata: [1:0] opcode, [33:2] address, [65:34] length, [71:66] zero
    input  wire logic [71:0] i_s_axis_tdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: [2:0] status, [3] trimmed, [7:4] zero
    output logic      [7:0]  o_m_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready
);
    import art_pkg::*;

    localparam int IW    = $clog2(TABLE_ENTRIES);
    localparam int RAM_W = ADDR_W + LEN_W;

    t_state r_state, n_state;

    // Request word
    t_op                r_op;
    logic [ADDR_W-1:0]  r_addr;
    logic [LEN_W-1:0]   r_len;

    // Scan bookkeeping
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [IW-1:0]      r_idx;
    logic               r_pend;
    logic [IW-1:0]      r_pend_idx;
    logic               r_pend_v;
    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic [ADDR_W-1:0]  r_hit_base;
    logic [LEN_W-1:0]   r_hit_len;
    logic [END_W-1:0]   r_hit_end;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;

    // Decision
    t_act               r_act, n_act;
    logic [2:0]         r_status, n_status;
    logic               r_trim, n_trim;
    logic [END_W-1:0]   r_hole_end, n_hole_end;

    // RAM and compare unit
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic [RAM_W-1:0]   ram_rdata;
    t_cmp_res           cmp_res;
    logic               acc;
    logic               last_idx;
    logic               ent_match;

    assign acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign last_idx = (r_idx == IW'(TABLE_ENTRIES - 1));

    art_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    art_cmp u_cmp (
        .i_ent_base (ram_rdata[RAM_W-1:LEN_W]),
        .i_ent_len  (ram_rdata[LEN_W-1:0]),
        .i_q_addr   (r_addr),
        .i_q_len    (r_len),
        .o_res      (cmp_res)
    );

    assign ent_match = r_pend && r_pend_v &&
                       ((r_op == OP_ALLOC) ? cmp_res.overlap : cmp_res.contain);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_axis_tvalid) n_state = S_SCAN;
            S_SCAN:   if (last_idx) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_DECIDE;
            S_DECIDE: n_state = (n_act == ACT_NONE) ? S_RESP : S_WR_A;
            S_WR_A:   n_state = (r_act == ACT_SPLIT_TAIL) ? S_WR_B : S_RESP;
            S_WR_B:   n_state = S_RESP;
            S_RESP:   if (i_m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Handshake and table write outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = r_hit_idx;
        ram_wdata       = {r_hit_base, r_addr - r_hit_base};
        unique case (r_state)
            S_IDLE: o_s_axis_tready = 1'b1;
            S_WR_A: begin
                case (r_act)
                    ACT_ALLOC: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_free_idx;
                        ram_wdata = {r_addr, r_len};
                    end
                    ACT_TRIM: begin
                        ram_we    = 1'b1;
                        ram_wdata = {r_hit_base + r_len, r_hit_len - r_len};
                    end
                    ACT_SPLIT, ACT_SPLIT_TAIL: ram_we = 1'b1;
                    default: ram_we = 1'b0;
                endcase
            end
            S_WR_B: begin
                ram_we    = 1'b1;
                ram_waddr = r_free_idx;
                ram_wdata = {r_hole_end[ADDR_W-1:0], LEN_W'(r_hit_end - r_hole_end)};
            end
            S_RESP: o_m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign o_m_axis_tdata = {4'b0000, r_trim, r_status};

    // Decision after the scan
    always_comb begin
        n_act      = ACT_NONE;
        n_status   = ST_OK;
        n_trim     = 1'b0;
        n_hole_end = {1'b0, r_addr} + {1'b0, r_len};
        if (r_op == OP_ALLOC) begin
            if (r_len == '0) begin
                n_status = ST_OK;
            end else if (r_hit) begin
                n_status = ST_OVERLAP;
            end else if (!r_free_found) begin
                n_status = ST_FULL;
            end else begin
                n_act = ACT_ALLOC;
            end
        end else if (r_addr == '0) begin
            n_status = ST_OK;
        end else if (!r_hit) begin
            n_status = ST_NOT_ALLOC;
        end else if (r_hit_base == r_addr) begin
            if (r_op == OP_FREE) begin
                n_act = ACT_REMOVE;
            end else if (r_len < r_hit_len) begin
                n_act  = ACT_TRIM;
                n_trim = 1'b1;
                if (r_op == OP_FREE_EXACT) n_status = ST_MISMATCH;
            end else if (r_op == OP_FREE_EXACT && r_len != r_hit_len) begin
                n_status = ST_MISMATCH;
            end else begin
                n_act = ACT_REMOVE;
            end
        end else if (r_op != OP_FREE_ANY) begin
            n_status = ST_INSIDE;
        end else if (n_hole_end < r_hit_end) begin
            if (!r_free_found) begin
                n_status = ST_FULL;
            end else begin
                n_act  = ACT_SPLIT_TAIL;
                n_trim = 1'b1;
            end
        end else begin
            n_act  = ACT_SPLIT;
            n_trim = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_pend  <= 1'b0;
            r_idx   <= '0;
            r_act   <= ACT_NONE;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_SCAN);
            if (acc) begin
                r_idx <= '0;
            end else if (r_state == S_SCAN && !last_idx) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == S_DECIDE) r_act <= n_act;
            // valid bit updates
            if (r_state == S_WR_A) begin
                if (r_act == ACT_ALLOC)  r_valid[r_free_idx] <= 1'b1;
                if (r_act == ACT_REMOVE) r_valid[r_hit_idx]  <= 1'b0;
            end
            if (r_state == S_WR_B) r_valid[r_free_idx] <= 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op         <= t_op'(i_s_axis_tdata[1:0]);
            r_addr       <= i_s_axis_tdata[33:2];
            r_len        <= i_s_axis_tdata[65:34];
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            // lowest free slot, found as entries are issued
            if (r_state == S_SCAN && !r_valid[r_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_idx;
            end
            // first matching entry from the compare unit
            if (ent_match && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_pend_idx;
                r_hit_base <= ram_rdata[RAM_W-1:LEN_W];
                r_hit_len  <= ram_rdata[LEN_W-1:0];
                r_hit_end  <= cmp_res.ent_end;
            end
        end
        r_pend_idx <= r_idx;
        r_pend_v   <= r_valid[r_idx];
        if (r_state == S_DECIDE) begin
            r_status   <= n_status;
            r_trim     <= n_trim;
            r_hole_end <= n_hole_end;
        end
    end

    // Request and response never overlap
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("accepting while a response is pending");

    // An accepted word always starts a scan
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_state == S_SCAN))
        else $error("accept did not start a scan");

    // Read data is only consumed during the scan window
    a_pend_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("scan data outside scan window");

    // Trimmed is only reported with ok or size mismatch
    a_trim_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[3]) |->
        (o_m_axis_tdata[2:0] == ST_OK || o_m_axis_tdata[2:0] == ST_MISMATCH))
        else $error("trimmed with bad status");

endmodule

`default_nettype wire

>>> design/art_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module art_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/art_cmp.sv
// Shared range compare unit: tests one stored entry against the current word.
`default_nettype none

module art_cmp (
    input  wire logic [art_pkg::ADDR_W-1:0] i_ent_base,
    input  wire logic [art_pkg::LEN_W-1:0]  i_ent_len,
    input  wire logic [art_pkg::ADDR_W-1:0] i_q_addr,
    input  wire logic [art_pkg::LEN_W-1:0]  i_q_len,
    output art_pkg::t_cmp_res               o_res
);
    import art_pkg::*;

    logic [END_W-1:0] ent_end;
    logic [END_W-1:0] q_end;

    // Ends are 33-bit so a range never wraps
    assign ent_end = {1'b0, i_ent_base} + {1'b0, i_ent_len};
    assign q_end   = {1'b0, i_q_addr} + {1'b0, i_q_len};

    assign o_res.ent_end = ent_end;
    assign o_res.overlap = ({1'b0, i_q_addr} < ent_end) && ({1'b0, i_ent_base} < q_end);
    assign o_res.contain = (i_q_addr >= i_ent_base) && ({1'b0, i_q_addr} < ent_end);

endmodule

`default_nettype wire
